FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files.
// Every check is clocked on clk and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define AMVT_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define AMVT_IMPLY(label, ante, cons, msg) \
	`AMVT_CHECK(label, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/amvt_pkg.sv
// ----------------------------------------------------------------------------
// amvt_pkg
// Types, constants and single-precision helper functions of the axis matrix
// vector transform.
// ----------------------------------------------------------------------------
package amvt_pkg;

	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

	typedef struct packed {
		logic [31:0] axis_00;
		logic [31:0] axis_01;
		logic [31:0] axis_02;
		logic [31:0] axis_10;
		logic [31:0] axis_11;
		logic [31:0] axis_12;
		logic [31:0] axis_20;
		logic [31:0] axis_21;
		logic [31:0] axis_22;
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
	} amvt_in_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
	} amvt_out_t;

	function automatic logic f_is_nan(input logic [31:0] a);
		return a[30:0] > INF_MAG;
	endfunction

	function automatic logic f_is_inf(input logic [31:0] a);
		return a[30:0] == INF_MAG;
	endfunction

	function automatic logic f_is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	// Subnormals use exponent one and no hidden bit.
	function automatic logic [7:0] f_exp(input logic [31:0] a);
		return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
	endfunction

	function automatic logic [23:0] f_sig(input logic [31:0] a);
		return {(a[30:23] != 8'd0), a[22:0]};
	endfunction

	function automatic logic [5:0] lzc56(input logic [55:0] v);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < 56; i++) begin
			if (v[i]) n = 6'(55 - i);
		end
		return n;
	endfunction

	// Rounds a significand whose leading one sits in bit 55, with the biased
	// exponent that belongs to that leading one, to nearest even.
	function automatic logic [31:0] round_pack(input logic sign, input logic [55:0] sig,
			input logic signed [10:0] bexp);
		logic signed [10:0] be;
		logic signed [10:0] bm1;
		logic [5:0]  rs;
		logic [55:0] sh;
		logic        lost;
		logic [23:0] mant;
		logic        up;
		logic [32:0] bits;
		be = bexp;
		rs = 6'd0;
		if (bexp < 11'sd1) begin
			if (bexp < -11'sd48) rs = 6'd49;
			else rs = 6'(11'sd1 - bexp);
			be = 11'sd1;
		end
		sh   = sig >> rs;
		lost = ((sh << rs) != sig);
		mant = sh[55:32];
		up   = sh[31] & ((|sh[30:0]) | lost | mant[0]);
		bm1  = be - 11'sd1;
		bits = {2'b00, bm1[7:0], 23'd0} + {9'd0, mant} + {32'd0, up};
		if (be > 11'sd254 || bits >= 33'h0_7F80_0000) return {sign, INF_MAG};
		return {sign, bits[30:0]};
	endfunction

endpackage

FILE: hw/rtl/amvt_fmul.sv
// ----------------------------------------------------------------------------
// amvt_fmul
// Three-stage single-precision multiplier: product, normalise, round.
// ----------------------------------------------------------------------------
module amvt_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] result
);
	import amvt_pkg::*;

	logic        valid_s1, valid_s2, valid_s3;
	logic [47:0] prod_s1;
	logic signed [10:0] bexp_s1, bexp_s2;
	logic        sign_s1, sign_s2;
	logic        spec_s1, spec_s2;
	logic [31:0] specv_s1, specv_s2;
	logic [55:0] norm_s2;
	logic [31:0] res_s3;

	logic        sign_c, spec_c;
	logic [31:0] specv_c;
	logic [5:0]  lz_c;

	always_comb begin
		sign_c  = a[31] ^ b[31];
		spec_c  = 1'b1;
		specv_c = QNAN_BITS;
		if (f_is_nan(a) || f_is_nan(b)) begin
			specv_c = QNAN_BITS;
		end else if (f_is_inf(a) || f_is_inf(b)) begin
			specv_c = (f_is_zero(a) || f_is_zero(b)) ? QNAN_BITS : {sign_c, INF_MAG};
		end else if (f_is_zero(a) || f_is_zero(b)) begin
			specv_c = {sign_c, 31'd0};
		end else begin
			spec_c = 1'b0;
		end
	end

	assign lz_c = lzc56({prod_s1, 8'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= {24'd0, f_sig(a)} * {24'd0, f_sig(b)};
		bexp_s1  <= $signed({3'b000, f_exp(a)}) + $signed({3'b000, f_exp(b)}) - 11'sd126;
		sign_s1  <= sign_c;
		spec_s1  <= spec_c;
		specv_s1 <= specv_c;

		norm_s2  <= {prod_s1, 8'd0} << lz_c;
		bexp_s2  <= bexp_s1 - $signed({5'd0, lz_c});
		sign_s2  <= sign_s1;
		spec_s2  <= spec_s1;
		specv_s2 <= specv_s1;

		res_s3   <= spec_s2 ? specv_s2 : round_pack(sign_s2, norm_s2, bexp_s2);
	end

	assign out_valid = valid_s3;
	assign result    = res_s3;

endmodule

FILE: hw/rtl/amvt_fadd.sv
// ----------------------------------------------------------------------------
// amvt_fadd
// Three-stage single-precision adder: align and add, normalise, round.
// ----------------------------------------------------------------------------
module amvt_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] result
);
	import amvt_pkg::*;

	logic        valid_s1, valid_s2, valid_s3;
	logic [54:0] sum_s1;
	logic signed [10:0] bexp_s1, bexp_s2;
	logic        sign_s1, sign_s2;
	logic        spec_s1, spec_s2;
	logic [31:0] specv_s1, specv_s2;
	logic [55:0] norm_s2;
	logic [31:0] res_s3;

	logic        swap_c, sbig_c, spec_c;
	logic [31:0] specv_c;
	logic [7:0]  ebig_c, esml_c, d_c;
	logic [5:0]  dcap_c;
	logic [53:0] big_c, ms_c, sh_c, small_c;
	logic [54:0] sum_c;
	logic [5:0]  lz_c;

	always_comb begin
		swap_c  = a[30:0] < b[30:0];
		sbig_c  = swap_c ? b[31] : a[31];
		ebig_c  = swap_c ? f_exp(b) : f_exp(a);
		esml_c  = swap_c ? f_exp(a) : f_exp(b);
		big_c   = {(swap_c ? f_sig(b) : f_sig(a)), 30'd0};
		ms_c    = {(swap_c ? f_sig(a) : f_sig(b)), 30'd0};
		d_c     = ebig_c - esml_c;
		dcap_c  = (d_c > 8'd63) ? 6'd63 : d_c[5:0];
		sh_c    = ms_c >> dcap_c;
		// Bits shifted out leave a sticky one in the lowest place.
		small_c = sh_c | {53'd0, ((sh_c << dcap_c) != ms_c)};
		if (a[31] == b[31]) sum_c = {1'b0, big_c} + {1'b0, small_c};
		else sum_c = {1'b0, big_c} - {1'b0, small_c};

		spec_c  = 1'b1;
		specv_c = QNAN_BITS;
		if (f_is_nan(a) || f_is_nan(b)) begin
			specv_c = QNAN_BITS;
		end else if (f_is_inf(a) && f_is_inf(b)) begin
			specv_c = (a[31] == b[31]) ? a : QNAN_BITS;
		end else if (f_is_inf(a)) begin
			specv_c = a;
		end else if (f_is_inf(b)) begin
			specv_c = b;
		end else if (f_is_zero(a) && f_is_zero(b)) begin
			specv_c = {a[31] & b[31], 31'd0};
		end else if (f_is_zero(a)) begin
			specv_c = b;
		end else if (f_is_zero(b)) begin
			specv_c = a;
		end else if (sum_c == 55'd0) begin
			specv_c = 32'd0;
		end else begin
			spec_c = 1'b0;
		end
	end

	assign lz_c = lzc56({sum_s1, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1   <= sum_c;
		bexp_s1  <= $signed({3'b000, ebig_c}) + 11'sd1;
		sign_s1  <= sbig_c;
		spec_s1  <= spec_c;
		specv_s1 <= specv_c;

		norm_s2  <= {sum_s1, 1'b0} << lz_c;
		bexp_s2  <= bexp_s1 - $signed({5'd0, lz_c});
		sign_s2  <= sign_s1;
		spec_s2  <= spec_s1;
		specv_s2 <= specv_s1;

		res_s3   <= spec_s2 ? specv_s2 : round_pack(sign_s2, norm_s2, bexp_s2);
	end

	assign out_valid = valid_s3;
	assign result    = res_s3;

endmodule

FILE: hw/rtl/axis_matrix_vector_transform.sv
// Throughput: one word per cycle; busy is never raised, as the nine-stage
// multiply, add, add pipeline has no back-pressure. Each accepted word
// leaves the pipeline with a done strobe.
// Reset clears the stage valid bits only; nothing is kept between words.
// ----------------------------------------------------------------------------
// axis_matrix_vector_transform
// Single-precision 3x3 matrix times vector: nine multipliers and two ranks
// of adders, one result word per input word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module axis_matrix_vector_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  amvt_pkg::amvt_in_t  operand,
	output logic                done,
	output amvt_pkg::amvt_out_t result
);
	import amvt_pkg::*;

	logic        accept;
	logic [31:0] mul_a [9];
	logic [31:0] mul_b [9];
	logic [31:0] prod  [9];
	logic [8:0]  mul_v;
	logic [31:0] sum1  [3];
	logic [2:0]  add1_v;
	logic [31:0] sum2  [3];
	logic [2:0]  add2_v;
	logic [31:0] pdly_s1 [3];
	logic [31:0] pdly_s2 [3];
	logic [31:0] pdly_s3 [3];

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Pair order per lane: the first two products are added first.
	always_comb begin
		mul_a[0] = operand.vec_y; mul_b[0] = operand.axis_10;
		mul_a[1] = operand.vec_z; mul_b[1] = operand.axis_20;
		mul_a[2] = operand.vec_x; mul_b[2] = operand.axis_00;
		mul_a[3] = operand.vec_x; mul_b[3] = operand.axis_01;
		mul_a[4] = operand.vec_y; mul_b[4] = operand.axis_11;
		mul_a[5] = operand.vec_z; mul_b[5] = operand.axis_21;
		mul_a[6] = operand.vec_x; mul_b[6] = operand.axis_02;
		mul_a[7] = operand.vec_y; mul_b[7] = operand.axis_12;
		mul_a[8] = operand.vec_z; mul_b[8] = operand.axis_22;
	end

	for (genvar i = 0; i < 9; i++) begin : g_mul
		amvt_fmul u_mul (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (accept),
			.a         (mul_a[i]),
			.b         (mul_b[i]),
			.out_valid (mul_v[i]),
			.result    (prod[i])
		);
	end

	for (genvar j = 0; j < 3; j++) begin : g_lane
		amvt_fadd u_add1 (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (mul_v[3*j]),
			.a         (prod[3*j]),
			.b         (prod[3*j+1]),
			.out_valid (add1_v[j]),
			.result    (sum1[j])
		);

		always_ff @(posedge clk) begin
			pdly_s1[j] <= prod[3*j+2];
			pdly_s2[j] <= pdly_s1[j];
			pdly_s3[j] <= pdly_s2[j];
		end

		amvt_fadd u_add2 (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (add1_v[j]),
			.a         (sum1[j]),
			.b         (pdly_s3[j]),
			.out_valid (add2_v[j]),
			.result    (sum2[j])
		);
	end

	assign done         = add2_v[0];
	assign result.out_x = sum2[0];
	assign result.out_y = sum2[1];
	assign result.out_z = sum2[2];

	`AMVT_IMPLY(a_done_latency, done, $past(start && !busy, 9), "done without a word nine cycles back")
	`AMVT_IMPLY(a_nan_x, done && (result.out_x[30:0] > INF_MAG), result.out_x == QNAN_BITS, "x NaN not canonical")
	`AMVT_IMPLY(a_nan_y, done && (result.out_y[30:0] > INF_MAG), result.out_y == QNAN_BITS, "y NaN not canonical")
	`AMVT_IMPLY(a_nan_z, done && (result.out_z[30:0] > INF_MAG), result.out_z == QNAN_BITS, "z NaN not canonical")

endmodule
